// ===== sv/weighted_block_sum_integral_table_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted block-sum integral table
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_BLOCK_SUM_INTEGRAL_TABLE_ASSERT_SVH
`define WEIGHTED_BLOCK_SUM_INTEGRAL_TABLE_ASSERT_SVH

// Same-cycle implication.
`define WBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WBST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wbst_pkg.sv =====
// ---------------------------------------------------------------------------
// wbst_pkg
// Widths, register indexes, divider handshake types and the cell weight rule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbst_pkg;

  localparam int GRID_SIZE = 32;
  localparam int POS_W     = $clog2(GRID_SIZE);
  localparam int SUM_W     = 36;
  localparam int VAL_W     = 64;
  localparam int DIM_W     = 15;
  localparam int WGT_W     = 11;
  localparam int FAC_W     = 21;
  localparam int M_W       = 51;
  localparam int ADDR_W    = 4;

  localparam logic [31:0] SCALE_ROUNDED = 32'd65536;
  localparam logic [31:0] SCALE_EXACT   = 32'd476985600;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 15'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 15'd1080;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ROUNDED = 2'd2;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Weight of grid cell idx along a dimension of dim pixels.
  function automatic logic [WGT_W-1:0] cell_weight(input logic [DIM_W-1:0] dim,
                                                   input logic [POS_W-1:0] idx);
    logic [9:0]         q;
    logic [20:0]        x0;
    logic [20:0]        x1;
    logic signed [17:0] e0;
    logic signed [17:0] e1;
    logic signed [17:0] span;
    q  = dim[DIM_W-1:5];
    x0 = 21'(dim) * 21'(idx);
    x1 = x0 + 21'(dim);
    e0 = $signed({2'b00, x0[20:5]}) - ((x0[4:0] == 5'd0) ? 18'sd1 : 18'sd0);
    e1 = $signed({2'b00, x1[20:5]}) - ((x1[4:0] == 5'd0) ? 18'sd1 : 18'sd0);
    span = e1 - e0;
    if (dim[4:0] == 5'd0 || q == 10'd0) begin
      cell_weight = WGT_W'(1);
    end else if (span == $signed({8'b0, q})) begin
      cell_weight = WGT_W'(q) + WGT_W'(1);
    end else begin
      cell_weight = WGT_W'(q);
    end
  endfunction

endpackage

// ===== sv/wbst_div.sv =====
// ---------------------------------------------------------------------------
// wbst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbst_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wbst_pkg::div_ctl_t        ctl,
  input  logic [wbst_pkg::VAL_W-1:0] dividend,
  input  logic [wbst_pkg::VAL_W-1:0] divisor,
  output wbst_pkg::div_sts_t        sts,
  output logic [wbst_pkg::VAL_W-1:0] quotient
);
  import wbst_pkg::*;

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0] quo_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] dvs_r;

  logic [VAL_W:0]   rem_sh;
  logic [VAL_W+1:0] diff;

  // Shift in the next dividend bit and trial-subtract.
  assign rem_sh = {rem_r, quo_r[VAL_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VAL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VAL_W-2:0], ~diff[VAL_W+1]};
      if (!diff[VAL_W+1]) begin
        rem_r <= diff[VAL_W-1:0];
      end else begin
        rem_r <= rem_sh[VAL_W-1:0];
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/weighted_block_sum_integral_table.sv =====
// ---------------------------------------------------------------------------
// weighted_block_sum_integral_table
// Weighted 32x32 summed-area table builder over per-block pixel sums.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one 36-bit block sum per transaction, grid raster order; in_tuser
//           set restarts at row 0, column 0 before the item is used.
//   out_* : one summed-area entry per input, with its grid row and column;
//           out_tlast marks row 31, column 31.
//   cfg_* : APB registers frame_width (0x0), frame_height (0x4),
//           rounded_mode (0x8); write only between items.
// Throughput: one item at a time. Exact mode runs a weight lookup, a shared
//   32x32 multiplier stepped through six products, then a finish step.
//   Rounded mode runs the multiply steps for the product and denominator,
//   then a 64-bit divider that yields one quotient bit per cycle.
// Latency: the result shows on out_tvalid the cycle after the finish step.
// Reset: rst_n clears position, row accumulator, output valid and restores
//   register defaults; the previous-row memory is not cleared.
// Stall: a result waits in the output register; the block takes the next
//   item meanwhile and holds its finish step until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_block_sum_integral_table (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [35:0] block_sum, [39:36] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,
  // in_tuser: [0] first_of_frame
  input  logic                              in_tuser,
  // out_tdata: [63:0] table_value, [68:64] grid_row, [73:69] grid_col, [79:74] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [79:0]                       out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wbst_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import wbst_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WGT  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Multiplier schedule
  localparam logic [3:0] STEP_AB   = 4'd0;
  localparam logic [3:0] STEP_SCL  = 4'd1;
  localparam logic [3:0] STEP_LL   = 4'd2;
  localparam logic [3:0] STEP_LH   = 4'd3;
  localparam logic [3:0] STEP_HL   = 4'd4;
  localparam logic [3:0] STEP_HH   = 4'd5;
  localparam logic [3:0] STEP_WW   = 4'd6;
  localparam logic [3:0] STEP_DEN  = 4'd7;
  localparam logic [3:0] STEP_DIV  = 4'd8;

  state_t state_r;

  // Configuration registers
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             rounded_r;
  logic             cfg_wr;

  // Position and item registers
  logic [POS_W-1:0] row_pos_r;
  logic [POS_W-1:0] col_pos_r;
  logic [POS_W-1:0] cur_row_r;
  logic [POS_W-1:0] cur_col_r;
  logic [POS_W-1:0] row_in;
  logic [POS_W-1:0] col_in;
  logic [SUM_W-1:0] sum_r;
  logic [WGT_W-1:0] wa_r;
  logic [WGT_W-1:0] wb_r;
  logic [3:0]       step_r;

  // Datapath
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [VAL_W-1:0] mul_r;
  logic [M_W-1:0]   m_r;
  logic [VAL_W-1:0] prod_r;
  logic [FAC_W-1:0] hh_r;
  logic [VAL_W-1:0] row_acc_r;
  logic [VAL_W-1:0] wtd;
  logic [VAL_W-1:0] acc_nxt;
  logic [VAL_W-1:0] entry_nxt;

  // Previous-row memory
  logic [VAL_W-1:0] prev_mem [GRID_SIZE];
  logic [VAL_W-1:0] rd_data_r;

  // Output register
  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic             out_last_r;

  // Divider
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [VAL_W-1:0] div_quo;

  logic in_acc;
  logic out_free;
  logic finish;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      rounded_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WIDTH:   width_r   <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT:  height_r  <= cfg_pwdata[DIM_W-1:0];
        REG_ROUNDED: rounded_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:   cfg_prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT:  cfg_prdata = {{(32-DIM_W){1'b0}}, height_r};
      REG_ROUNDED: cfg_prdata = {31'b0, rounded_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Handshake and control
  // -------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign finish    = (state_r == ST_DONE) & out_free;

  // Restart position on first_of_frame
  assign row_in = in_tuser ? '0 : row_pos_r;
  assign col_in = in_tuser ? '0 : col_pos_r;

  assign div_ctl.start = (state_r == ST_MUL) && (step_r == STEP_DIV) && rounded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_pos_r <= '0;
      col_pos_r <= '0;
      step_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // advance the raster position
            if (col_in == POS_W'(GRID_SIZE - 1)) begin
              col_pos_r <= '0;
              row_pos_r <= row_in + POS_W'(1);
            end else begin
              col_pos_r <= col_in + POS_W'(1);
              row_pos_r <= row_in;
            end
            state_r <= ST_WGT;
          end
        end
        ST_WGT: begin
          step_r  <= STEP_AB;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          step_r <= step_r + 4'd1;
          if (step_r == STEP_HH && !rounded_r) begin
            state_r <= ST_DONE;
          end else if (step_r == STEP_DIV) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Item capture, weights and memory read
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sum_r     <= in_tdata[SUM_W-1:0];
      cur_row_r <= row_in;
      cur_col_r <= col_in;
      rd_data_r <= prev_mem[col_in];
    end
    if (state_r == ST_WGT) begin
      wa_r <= cell_weight(height_r, cur_row_r);
      wb_r <= cell_weight(width_r, cur_col_r);
    end
  end

  // -------------------------------------------------------------------------
  // Shared multiplier: sum*a*b*scale mod 2^64, then the rounded denominator
  // -------------------------------------------------------------------------
  always_comb begin
    case (step_r)
      STEP_AB: begin
        mul_a = 32'(wa_r);
        mul_b = 32'(wb_r);
      end
      STEP_SCL: begin
        mul_a = mul_r[31:0];
        mul_b = rounded_r ? SCALE_ROUNDED : SCALE_EXACT;
      end
      STEP_LL: begin
        mul_a = mul_r[31:0];
        mul_b = sum_r[31:0];
      end
      STEP_LH: begin
        mul_a = m_r[31:0];
        mul_b = {{(64-SUM_W){1'b0}}, sum_r[SUM_W-1:32]};
      end
      STEP_HL: begin
        mul_a = {{(64-M_W){1'b0}}, m_r[M_W-1:32]};
        mul_b = sum_r[31:0];
      end
      STEP_HH: begin
        mul_a = 32'(height_r[DIM_W-1:5]);
        mul_b = (height_r[4:0] != 5'd0) ? 32'(height_r[DIM_W-1:5]) + 32'd1 : 32'd1;
      end
      STEP_WW: begin
        mul_a = 32'(width_r[DIM_W-1:5]);
        mul_b = (width_r[4:0] != 5'd0) ? 32'(width_r[DIM_W-1:5]) + 32'd1 : 32'd1;
      end
      STEP_DEN: begin
        mul_a = 32'(hh_r);
        mul_b = mul_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      mul_r <= 64'(mul_a) * 64'(mul_b);
      case (step_r)
        STEP_LL: m_r    <= mul_r[M_W-1:0];
        STEP_LH: prod_r <= mul_r;
        STEP_HL: prod_r <= prod_r + {mul_r[31:0], 32'b0};
        STEP_HH: prod_r <= prod_r + {mul_r[31:0], 32'b0};
        STEP_WW: hh_r   <= mul_r[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  wbst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (prod_r),
    .divisor  (mul_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // -------------------------------------------------------------------------
  // Finish: accumulate, add the row above, write back, load the output
  // -------------------------------------------------------------------------
  assign wtd       = rounded_r ? div_quo : prod_r;
  assign acc_nxt   = ((cur_col_r == '0) ? '0 : row_acc_r) + wtd;
  assign entry_nxt = (cur_row_r != '0) ? rd_data_r + acc_nxt : acc_nxt;

  always_ff @(posedge clk) begin
    if (finish) begin
      prev_mem[cur_col_r] <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_acc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        row_acc_r   <= acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_val_r  <= entry_nxt;
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
      out_last_r <= (cur_row_r == POS_W'(GRID_SIZE - 1)) &&
                    (cur_col_r == POS_W'(GRID_SIZE - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `include "weighted_block_sum_integral_table_assert.svh"

  `WBST_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `WBST_ASSERT_IMP(a_div_mode, div_ctl.start, rounded_r, "divider started in exact mode")
  `WBST_ASSERT_IMP(a_div_idle, state_r == ST_IDLE, !div_sts.busy, "divider busy while idle")

endmodule

// ===== test/tb_weighted_block_sum_integral_table.sv =====
// ---------------------------------------------------------------------------
// tb_weighted_block_sum_integral_table
// Self-checking bench for the weighted 32x32 summed-area table builder. A
// driver feeds block sums from a queue, a built-in predictor computes the
// table entry for every accepted sum, and a monitor checks each output
// transaction against it. Register settings change between phases while the
// block is idle; both stream sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_block_sum_integral_table;

  import wbst_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;     // unmapped, must be ignored
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BLOCKS  = 140;
  localparam int RESTART_FROM  = 1060;         // no restarts before one full frame
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 100;          // outlasts one item on the rounded path
  localparam int WATCHDOG_MAX  = 2000;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             first;
  } block_item_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } sat_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  weighted_block_sum_integral_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stimulus and expectation stores.
  block_item_t block_queue[$];
  sat_entry_t  expected_entries[$];
  int          blocks_queued = 0;
  int          entries_seen = 0;
  int          error_count = 0;
  int          gap_max = 4;
  int          stall_max = 4;

  // Shadow registers, reset values as after rst_n.
  logic [DIM_W-1:0] shadow_width = WIDTH_RST;
  logic [DIM_W-1:0] shadow_height = HEIGHT_RST;
  logic             shadow_rounded = 1'b0;

  // Predictor state: running row sum, last row of the table and position.
  logic [VAL_W-1:0] row_sum = '0;
  logic [VAL_W-1:0] upper_row [GRID_SIZE];
  logic [POS_W-1:0] cur_row = '0;
  logic [POS_W-1:0] cur_col = '0;

  // Last pixel index inside grid edge n; -1 for the left/top edge.
  function automatic longint pixel_edge(input int unsigned dim, input int unsigned n);
    longint x;
    x = longint'(dim) * longint'(n);
    if (x % GRID_SIZE == 0) return x / GRID_SIZE - 1;
    return x / GRID_SIZE;
  endfunction

  // Weight of grid cell idx: narrow cells get q+1, wide cells q.
  function automatic logic [VAL_W-1:0] dim_weight(input int unsigned dim,
                                                  input int unsigned idx);
    int unsigned q;
    longint      span;
    q = dim / GRID_SIZE;
    if (dim % GRID_SIZE == 0 || q == 0) return 1;
    span = pixel_edge(dim, idx + 1) - pixel_edge(dim, idx);
    return (span == longint'(q)) ? VAL_W'(q) + 1 : VAL_W'(q);
  endfunction

  function automatic logic [VAL_W-1:0] dim_factor(input int unsigned dim);
    logic [VAL_W-1:0] q;
    q = VAL_W'(dim / GRID_SIZE);
    return (dim % GRID_SIZE != 0) ? q * (q + 1) : q;
  endfunction

  // Weight one accepted block sum, fold it into the table and queue the
  // entry the block must produce for it.
  task automatic integrate_block(input logic [SUM_W-1:0] sum, input logic first);
    logic [VAL_W-1:0] scale;
    logic [VAL_W-1:0] denom;
    logic [VAL_W-1:0] prod;
    logic [VAL_W-1:0] weighted;
    sat_entry_t       e;
    if (first) begin
      cur_row = '0;
      cur_col = '0;
    end
    if (cur_col == 0) row_sum = '0;
    if (shadow_rounded) begin
      scale = VAL_W'(SCALE_ROUNDED);
      denom = dim_factor(shadow_height) * dim_factor(shadow_width);
    end else begin
      scale = VAL_W'(SCALE_EXACT);
      denom = 1;
    end
    prod = VAL_W'(sum) * dim_weight(shadow_height, cur_row) *
           dim_weight(shadow_width, cur_col) * scale;
    weighted = (denom != 0) ? prod / denom : {VAL_W{1'b1}};
    row_sum += weighted;
    e.value = (cur_row != 0) ? upper_row[cur_col] + row_sum : row_sum;
    upper_row[cur_col] = e.value;
    e.row  = cur_row;
    e.col  = cur_col;
    e.last = (cur_row == GRID_SIZE - 1) && (cur_col == GRID_SIZE - 1);
    expected_entries.push_back(e);
    if (cur_col == GRID_SIZE - 1) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  // Driver: present one block per transaction, then hold off for a random
  // gap before the next one.
  int          gap_left = 0;
  block_item_t next_block;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        integrate_block(in_tdata[SUM_W-1:0], in_tuser);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (block_queue.size() != 0) begin
          next_block = block_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, next_block.sum};
          in_tuser  <= next_block.first;
          gap_left  = $urandom_range(0, gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expectation,
  // then draw a stall before taking the next one.
  int         stall_left = 0;
  sat_entry_t got;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (out_tvalid && out_tready) begin
      entries_seen++;
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected entry, expected none, got %h", $time, out_tdata);
        error_count++;
      end else begin
        got = expected_entries.pop_front();
        if (out_tdata[63:0] !== got.value) begin
          $display("%0t: table_value expected %h got %h", $time, got.value,
                   out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[68:64] !== got.row) begin
          $display("%0t: grid_row expected %0d got %0d", $time, got.row,
                   out_tdata[68:64]);
          error_count++;
        end
        if (out_tdata[73:69] !== got.col) begin
          $display("%0t: grid_col expected %0d got %0d", $time, got.col,
                   out_tdata[73:69]);
          error_count++;
        end
        if (out_tlast !== got.last) begin
          $display("%0t: last expected %b got %b", $time, got.last, out_tlast);
          error_count++;
        end
      end
      stall_left = $urandom_range(0, stall_max);
      out_tready <= (stall_left == 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= (stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Two-phase register write; update the shadow copy at the access edge.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WIDTH:   shadow_width = data[DIM_W-1:0];
      REG_HEIGHT:  shadow_height = data[DIM_W-1:0];
      REG_ROUNDED: shadow_rounded = data[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input logic rnd);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_ROUNDED, {31'b0, rnd});
  endtask

  function automatic void queue_block(input logic first, input logic [SUM_W-1:0] sum);
    block_item_t b;
    b.first = first;
    b.sum   = sum;
    block_queue.push_back(b);
    blocks_queued++;
  endfunction

  // Hold the sender until every queued block has come back as an entry.
  task automatic drain();
    while (entries_seen != blocks_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SUM_W-1:0] draw_sum();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SUM_W'($urandom_range(0, 255));
      default: return SUM_W'({$urandom, $urandom});
    endcase
  endfunction

  // Mix of divisible, odd, tiny and extreme frame dimensions.
  function automatic int unsigned draw_dim();
    case ($urandom_range(0, 11))
      0:       return 32;
      1:       return 16384;
      2:       return 1920;
      3:       return 1080;
      4:       return 33;
      5:       return 16383;
      6:       return 720;
      7:       return $urandom_range(0, 31);
      8:       return $urandom_range(0, 32767);
      default: return $urandom_range(32, 16384);
    endcase
  endfunction

  int rand_index = 0;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default registers, extreme sums, then a restart mid-frame.
    queue_block(1'b1, '1);
    queue_block(1'b0, '0);
    queue_block(1'b0, '1);
    queue_block(1'b0, 36'd1);
    queue_block(1'b0, '1);
    queue_block(1'b0, draw_sum());
    queue_block(1'b1, '1);
    queue_block(1'b0, '1);
    queue_block(1'b0, '0);
    queue_block(1'b0, draw_sum());
    drain();

    // Dimensions below the grid: unit weights and a zero denominator.
    set_frame(5, 0, 1'b1);
    repeat (3) queue_block(1'b0, '1);
    drain();

    // Largest width field value with a height of 16384, rounded mode.
    set_frame(32767, 16384, 1'b1);
    queue_block(1'b0, '1);
    queue_block(1'b0, draw_sum());
    queue_block(1'b0, '1);
    drain();

    // Odd dimensions just above and below a multiple of the grid.
    set_frame(33, 16383, 1'b1);
    repeat (3) queue_block(1'b0, draw_sum());
    drain();

    // Smallest legal frame; write the unmapped slot, which must change nothing.
    set_frame(32, 32, 1'b0);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    queue_block(1'b0, '1);
    queue_block(1'b0, '0);
    queue_block(1'b0, draw_sum());
    drain();

    // Random phases: the frame carries on across register changes; restarts
    // only once a full grid, its last entry and the wrap have gone through.
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_frame(draw_dim(), draw_dim(), 1'($urandom_range(0, 1)));
      gap_max   = (p % 2 == 1) ? 0 : 4;
      stall_max = (p % 4 >= 2) ? 0 : 4;
      for (int k = 0; k < PHASE_BLOCKS; k++) begin
        queue_block((rand_index >= RESTART_FROM) && ($urandom_range(0, 15) == 0),
                    draw_sum());
        rand_index++;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_entries.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wbst_pkg.sv
sv/wbst_div.sv
sv/weighted_block_sum_integral_table.sv
test/tb_weighted_block_sum_integral_table.sv
